>>> rtl/core/reorder_window_ack_tracker_macros.svh
// Assertion macros used by the checker file rwat_checker.sv.
`ifndef REORDER_WINDOW_ACK_TRACKER_MACROS_SVH
`define REORDER_WINDOW_ACK_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWAT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rwat assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RWAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rwat assertion failed");

`endif

>>> rtl/core/rwat_pkg.sv
package rwat_pkg;

    localparam int SEQ_W   = 32;
    localparam int MAP_W   = 32;
    localparam int RUN_W   = 5;
    localparam int AHEAD_W = 5;
    localparam int ACT_W   = 3;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HELD    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STORE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_OLD     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FAR     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd5;

    localparam logic CMD_ARRIVED = 1'b0;
    localparam logic CMD_SENT    = 1'b1;

    typedef struct packed {
        logic             command;
        logic             payload_flag;
        logic [SEQ_W-1:0] sequence_req;
    } rwat_in_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SEQ_W-1:0] deliver_sequence;
        logic             last;
        logic [SEQ_W-1:0] cum_ack_seq;
        logic [MAP_W-1:0] sack_map;
        logic             ack_pending;
    } rwat_out_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SEQ_W-1:0] sequence_num;
        logic [RUN_W-1:0] run_len;
        logic [SEQ_W-1:0] cum_ack_seq;
        logic [MAP_W-1:0] sack_map;
        logic             ack_pending;
    } rwat_entry_t;

endpackage

>>> rtl/core/reorder_window_ack_tracker.sv
// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   rwat_pkg::rwat_in_t (one packet event)
// m_        out        m_valid/m_ready   rwat_pkg::rwat_out_t (one action)
// APB       in         psel/penable      max_reorder_ahead at byte address 0
//
// An item passes the front through capture, classify and hand-off; an in-order arrival
// also runs a release step per held packet that it frees. The front handles one item
// at a time. The back emits one result per cycle, unless m_ready stalls it, from a
// two-entry queue. Reset is synchronous and active low and resets the sequence state.
// Either channel may stall; the queue and the output register decouple them.
module reorder_window_ack_tracker #(
    parameter int WINDOW = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rwat_pkg::rwat_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output rwat_pkg::rwat_out_t m_payload,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int LIMIT = (WINDOW - 1 < 31) ? WINDOW - 1 : 31;
    localparam int AHEAD_W = rwat_pkg::AHEAD_W;

    logic [AHEAD_W-1:0] max_ahead_reg, max_ahead_next;
    logic reg_sel;

    logic push_valid, push_ready, pop_valid, pop_ready;
    rwat_pkg::rwat_entry_t push_entry, pop_entry;

    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(32 - AHEAD_W){1'b0}}, max_ahead_reg} : '0;

    always_comb begin
        max_ahead_next = max_ahead_reg;
        if (psel && penable && pwrite && reg_sel) begin
            max_ahead_next = pwdata[AHEAD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ahead_reg <= '0;
        end else begin
            max_ahead_reg <= max_ahead_next;
        end
    end

    rwat_front #(
        .LIMIT(LIMIT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .max_ahead (max_ahead_reg),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_entry(push_entry)
    );

    rwat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_entry(push_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry)
    );

    rwat_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_entry(pop_entry),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule

>>> rtl/core/rwat_queue.sv
module rwat_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  rwat_pkg::rwat_entry_t push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output rwat_pkg::rwat_entry_t pop_entry
);

    localparam int DEPTH = rwat_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rwat_pkg::rwat_entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/rwat_front.sv
module rwat_front #(
    parameter int LIMIT = 31
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rwat_pkg::rwat_in_t                  s_payload,
    input  logic [rwat_pkg::AHEAD_W-1:0]        max_ahead,
    output logic                                push_valid,
    input  logic                                push_ready,
    output rwat_pkg::rwat_entry_t               push_entry
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    localparam int SEQ_W = rwat_pkg::SEQ_W;
    localparam int MAP_W = rwat_pkg::MAP_W;
    localparam int RUN_W = rwat_pkg::RUN_W;

    logic [1:0] state_reg, state_next;
    logic [SEQ_W-1:0] next_exp_reg, next_exp_next;
    logic [MAP_W-1:0] held_map_reg, held_map_next;
    logic ack_owed_reg, ack_owed_next;

    rwat_pkg::rwat_in_t in_reg, in_next;
    logic [rwat_pkg::ACT_W-1:0] act_reg, act_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic [SEQ_W-1:0] diff;
    logic is_old, is_equal, too_far, already_held;

    assign diff         = in_reg.sequence_req - next_exp_reg;
    assign is_old       = in_reg.sequence_req < next_exp_reg;
    assign is_equal     = in_reg.sequence_req == next_exp_reg;
    assign too_far      = (diff > SEQ_W'(LIMIT))
                       || ((max_ahead != '0) && (diff > SEQ_W'(max_ahead)));
    assign already_held = held_map_reg[diff[RUN_W-1:0]];

    assign s_ready    = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);

    always_comb begin
        push_entry.action       = act_reg;
        push_entry.sequence_num = seq_reg;
        push_entry.run_len      = run_reg;
        push_entry.cum_ack_seq  = (next_exp_reg != '0) ? next_exp_reg - 1'b1 : '0;
        push_entry.sack_map     = {held_map_reg[MAP_W-1:1], 1'b0};
        push_entry.ack_pending  = ack_owed_reg;
    end

    always_comb begin
        state_next    = state_reg;
        next_exp_next = next_exp_reg;
        held_map_next = held_map_reg;
        ack_owed_next = ack_owed_reg;
        in_next       = in_reg;
        act_next      = act_reg;
        seq_next      = seq_reg;
        run_next      = run_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_payload;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                run_next   = '0;
                seq_next   = in_reg.sequence_req;
                state_next = ST_PUSH;
                priority if (in_reg.command == rwat_pkg::CMD_SENT) begin
                    ack_owed_next = 1'b0;
                    act_next      = rwat_pkg::ACT_NONE;
                    seq_next      = '0;
                end else if (!in_reg.payload_flag) begin
                    act_next = rwat_pkg::ACT_NONE;
                    seq_next = '0;
                end else begin
                    ack_owed_next = 1'b1;
                    priority if (is_old) begin
                        act_next = rwat_pkg::ACT_OLD;
                    end else if (is_equal) begin
                        act_next      = rwat_pkg::ACT_DELIVER;
                        next_exp_next = next_exp_reg + 1'b1;
                        held_map_next = held_map_reg >> 1;
                        state_next    = ST_RUN;
                    end else if (too_far) begin
                        act_next = rwat_pkg::ACT_FAR;
                    end else if (already_held) begin
                        act_next = rwat_pkg::ACT_OLD;
                    end else begin
                        act_next      = rwat_pkg::ACT_STORE;
                        held_map_next = held_map_reg
                                      | (MAP_W'(1) << diff[RUN_W-1:0]);
                    end
                end
            end
            ST_RUN: begin
                if (held_map_reg[0]) begin
                    next_exp_next = next_exp_reg + 1'b1;
                    held_map_next = held_map_reg >> 1;
                    run_next      = run_reg + 1'b1;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            next_exp_reg <= SEQ_W'(1);
            held_map_reg <= '0;
            ack_owed_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            held_map_reg <= held_map_next;
            ack_owed_reg <= ack_owed_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        act_reg <= act_next;
        seq_reg <= seq_next;
        run_reg <= run_next;
    end

endmodule

>>> rtl/core/rwat_back.sv
module rwat_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  rwat_pkg::rwat_entry_t pop_entry,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rwat_pkg::rwat_out_t   m_payload
);

    localparam int RUN_W = rwat_pkg::RUN_W;
    localparam int SEQ_W = rwat_pkg::SEQ_W;

    logic [RUN_W-1:0] index_reg, index_next;
    logic m_valid_reg, m_valid_next;
    rwat_pkg::rwat_out_t out_reg, out_next;
    logic out_free, emit, is_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = pop_valid && out_free;
    assign is_last   = (index_reg == pop_entry.run_len);
    assign pop_ready = emit && is_last;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    always_comb begin
        index_next   = index_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        if (emit) begin
            m_valid_next              = 1'b1;
            index_next                = is_last ? '0 : index_reg + 1'b1;
            out_next.action           = (index_reg == '0) ? pop_entry.action
                                                          : rwat_pkg::ACT_HELD;
            out_next.deliver_sequence = pop_entry.sequence_num + SEQ_W'(index_reg);
            out_next.last             = is_last;
            out_next.cum_ack_seq      = pop_entry.cum_ack_seq;
            out_next.sack_map         = pop_entry.sack_map;
            out_next.ack_pending      = pop_entry.ack_pending;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            index_reg   <= index_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

>>> rtl/core/rwat_checker.sv
`include "reorder_window_ack_tracker_macros.svh"

module rwat_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input rwat_pkg::rwat_out_t m_payload
);

    `RWAT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `RWAT_ASSERT_SAME(a_none_single, aclk, aresetn, m_valid && (m_payload.action == rwat_pkg::ACT_NONE), m_payload.last && (m_payload.deliver_sequence == '0))
    `RWAT_ASSERT_SAME(a_single_actions, aclk, aresetn, m_valid && ((m_payload.action == rwat_pkg::ACT_STORE) || (m_payload.action == rwat_pkg::ACT_OLD) || (m_payload.action == rwat_pkg::ACT_FAR)), m_payload.last)
    `RWAT_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_valid && m_ready && !m_payload.last, !m_valid || (m_payload.action == rwat_pkg::ACT_HELD))

endmodule

bind reorder_window_ack_tracker rwat_checker u_rwat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);
